FILE: sv/crcbf_pkg.sv
// Shared constants, types and the CRC-32 byte fold for the CRC block framer.
package crcbf_pkg;

	localparam int PAYLOAD_BYTES = 28;
	localparam int INDEX_BITS    = 16;
	localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
	localparam int BLOCK_NUM_W   = 16;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_PAD  = 2'd1,
		KIND_CRC  = 2'd2
	} byte_kind_t;

	// reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/crcbf_in_if.sv
// Input channel: message bytes with end-of-stream mark.
interface crcbf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source(output valid, output data_byte, output stream_end, input ready);
	modport sink(input valid, input data_byte, input stream_end, output ready);
endinterface

FILE: sv/crcbf_out_if.sv
// Output channel: framed record bytes with kind, block number and end marks.
interface crcbf_out_if
	import crcbf_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [7:0]             out_byte;
	logic [1:0]             byte_kind;
	logic [BLOCK_NUM_W-1:0] block_number;
	logic                   record_end;
	logic                   run_last;

	modport source(output valid, output out_byte, output byte_kind, output block_number,
		output record_end, output run_last, input ready);
	modport sink(input valid, input out_byte, input byte_kind, input block_number,
		input record_end, input run_last, output ready);
endinterface

FILE: sv/crc32_block_framer.sv
// Top level: CRC-32 block framer, cuts a byte stream into CRC-closed records.
// A data byte appears on the output in the cycle after its request is accepted.
// Throughput: one byte per cycle; a request that fills a block, or ends the stream,
// holds off input while its padding and four CRC bytes leave, one per free cycle.
// Input is also held off while the output register keeps a byte the sink has not taken.
// Reset (arst_n low): CRC all ones, block empty, block number zero, output empty.
module crc32_block_framer
	import crcbf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	crcbf_in_if.sink      in_ch,
	crcbf_out_if.source   out_ch
);

	typedef enum logic [1:0] {
		ST_DATA,
		ST_PAD,
		ST_CRC
	} state_t;

	state_t                 state_q;
	logic [31:0]            crc_q;
	logic [FILL_W-1:0]      fill_q;
	logic [INDEX_BITS-1:0]  index_q;
	logic                   last_q;
	logic [1:0]             crc_idx_q;

	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	byte_kind_t             out_kind_q;
	logic [BLOCK_NUM_W-1:0] out_block_q;
	logic                   out_rec_end_q;
	logic                   out_run_last_q;

	logic                   out_free;
	logic                   out_load;
	logic                   in_take;
	logic [31:0]            crc_in;
	logic [31:0]            crc_pad;
	logic [31:0]            crc_fin;
	logic [FILL_W-1:0]      fill_inc;
	logic                   fill_full;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_DATA) && out_free;
	assign in_take   = in_ch.valid && in_ch.ready;
	assign out_load  = in_take || (((state_q == ST_PAD) || (state_q == ST_CRC)) && out_free);
	assign crc_in    = crc_fold(crc_q, in_ch.data_byte);
	assign crc_pad   = crc_fold(crc_q, 8'd0);
	assign crc_fin   = ~crc_q;
	assign fill_inc  = fill_q + FILL_W'(1);
	assign fill_full = (fill_inc == FILL_W'(PAYLOAD_BYTES));

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.byte_kind    = out_kind_q;
	assign out_ch.block_number = out_block_q;
	assign out_ch.record_end   = out_rec_end_q;
	assign out_ch.run_last     = out_run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DATA;
			crc_q       <= CRC_INIT;
			fill_q      <= '0;
			index_q     <= '0;
			last_q      <= 1'b0;
			crc_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_DATA: begin
					if (in_take) begin
						out_valid_q    <= 1'b1;
						out_byte_q     <= in_ch.data_byte;
						out_kind_q     <= KIND_DATA;
						out_block_q    <= BLOCK_NUM_W'(index_q);
						out_rec_end_q  <= 1'b0;
						out_run_last_q <= !(fill_full || in_ch.stream_end);
						crc_q          <= crc_in;
						fill_q         <= fill_inc;
						last_q         <= in_ch.stream_end;
						crc_idx_q      <= '0;
						if (fill_full) begin
							state_q <= ST_CRC;
						end else if (in_ch.stream_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_byte_q     <= 8'd0;
						out_kind_q     <= KIND_PAD;
						out_block_q    <= BLOCK_NUM_W'(index_q);
						out_rec_end_q  <= 1'b0;
						out_run_last_q <= 1'b0;
						crc_q          <= crc_pad;
						fill_q         <= fill_inc;
						if (fill_full) begin
							state_q <= ST_CRC;
						end
					end
				end
				ST_CRC: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_byte_q     <= crc_fin[{crc_idx_q, 3'b000} +: 8];
						out_kind_q     <= KIND_CRC;
						out_block_q    <= BLOCK_NUM_W'(index_q);
						out_rec_end_q  <= (crc_idx_q == 2'd3);
						out_run_last_q <= (crc_idx_q == 2'd3);
						crc_idx_q      <= crc_idx_q + 2'd1;
						if (crc_idx_q == 2'd3) begin
							state_q <= ST_DATA;
							crc_q   <= CRC_INIT;
							fill_q  <= '0;
							index_q <= last_q ? '0 : index_q + INDEX_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= ST_DATA;
				end
			endcase
		end
	end

	a_ready_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == ST_DATA))
		else $error("input ready outside data phase");

	a_crc_needs_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRC) |-> (fill_q == FILL_W'(PAYLOAD_BYTES)))
		else $error("CRC trailer on a block that is not full");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= FILL_W'(PAYLOAD_BYTES)))
		else $error("fill count beyond payload size");

	a_record_end_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rec_end_q) |-> (out_kind_q == KIND_CRC && out_run_last_q))
		else $error("record end on a byte that is not the last CRC byte");

	a_pad_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_PAD) |-> !out_run_last_q)
		else $error("padding byte marked as last of its request");

endmodule
